// File: sv/gttt_pkg.sv
// ----------------------------------------------------------------------------
// Transposition table package
// Shared widths, codes, transaction structs and the mate-distance score helper.
// ----------------------------------------------------------------------------
package gttt_pkg;

  // Field widths fixed by the interface.
  localparam int KEY_W   = 64;
  localparam int SCORE_W = 16;
  localparam int DEPTH_W = 7;
  localparam int AGE_W   = 16;
  localparam int TYPE_W  = 2;
  localparam int MOVE_W  = 16;
  localparam int THR_W   = 15;

  // Defaults for the top-level parameters.
  localparam int INDEX_BITS_DEF = 12;
  localparam int MOVE_BITS_DEF  = 16;

  // Configuration reset value and replacement margin.
  localparam logic [THR_W-1:0] THR_RESET  = 15'd15000;
  localparam int               AGE_MARGIN = 32;

  // Transaction kinds.
  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Mate adjustment direction.
  localparam logic ADJ_TOWARD = 1'b0;
  localparam logic ADJ_AWAY   = 1'b1;

  // One accepted input transaction, less the best move.
  typedef struct packed {
    logic               kind;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [SCORE_W-1:0] score;
    logic [AGE_W-1:0]   age;
    logic [TYPE_W-1:0]  stype;
  } item_t;

  // One table slot, less the best move.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [AGE_W-1:0]   age;
    logic [TYPE_W-1:0]  stype;
  } slot_t;

  // One result transaction, less the best move.
  typedef struct packed {
    logic               hit;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [AGE_W-1:0]   age;
    logic [TYPE_W-1:0]  stype;
    logic               stored;
  } result_t;

  // Mate-distance adjustment: a score whose magnitude reaches the threshold
  // moves away from zero or toward zero by the depth, wrapping to 16 bits.
  function automatic logic [SCORE_W-1:0] mate_adjust(
    input logic [SCORE_W-1:0] s,
    input logic [DEPTH_W-1:0] d,
    input logic [THR_W-1:0]   thr,
    input logic               away
  );
    logic [SCORE_W-1:0] mag;
    logic [SCORE_W-1:0] dx;
    logic [SCORE_W-1:0] r;
    mag = s[SCORE_W-1] ? (~s + 16'd1) : s;
    dx  = SCORE_W'(d);
    if (mag < SCORE_W'(thr)) begin
      r = s;
    end else if (s[SCORE_W-1] == away) begin
      r = s - dx;
    end else begin
      r = s + dx;
    end
    return r;
  endfunction

endpackage

// File: sv/game_tree_transposition_table_core.sv
// ----------------------------------------------------------------------------
// Game-tree transposition table core
// Direct-mapped table of search results with mate-distance score handling.
// ----------------------------------------------------------------------------
// Usage:
// Input transactions (in_valid_i / in_ready_o) carry either a lookup or an
// update; kind_i selects which. Every input transaction gives exactly one
// output transaction (out_valid_o / out_ready_i): a lookup returns the hit
// flag and slot contents, an update returns the stored flag.
// Each transaction reads its slot in the cycle it is accepted and is resolved
// in the following cycle unless a result still waits unread; out_valid_o
// rises once the result is registered. The single table memory serves one
// transaction at a time: read for each, written only on a replacing update.
// A finished result waits in the output register while the next transaction
// is read; if the receiver stalls longer, the pending transaction holds and
// in_ready_o stays low until the output register frees up.
// After reset the table is cleared one slot per cycle, 2**INDEX_BITS slots
// (4096 by default), with in_ready_o low. cfg_we_i writes the mate threshold
// at any time, including during the clear; its reset value is 15000.
// ----------------------------------------------------------------------------
module game_tree_transposition_table_core #(
  parameter int INDEX_BITS = gttt_pkg::INDEX_BITS_DEF,
  parameter int MOVE_BITS  = gttt_pkg::MOVE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration
  input  logic                                cfg_we_i,
  input  logic [gttt_pkg::THR_W-1:0]          cfg_wdata_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [gttt_pkg::KEY_W-1:0]          hash_key_i,
  input  logic [gttt_pkg::DEPTH_W-1:0]        search_depth_i,
  input  logic signed [gttt_pkg::SCORE_W-1:0] new_score_i,
  input  logic [gttt_pkg::AGE_W-1:0]          new_age_i,
  input  logic [gttt_pkg::TYPE_W-1:0]         new_score_type_i,
  input  logic [gttt_pkg::MOVE_W-1:0]         new_best_move_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic signed [gttt_pkg::SCORE_W-1:0] found_score_o,
  output logic [gttt_pkg::DEPTH_W-1:0]        found_depth_o,
  output logic [gttt_pkg::AGE_W-1:0]          found_age_o,
  output logic [gttt_pkg::TYPE_W-1:0]         found_score_type_o,
  output logic [gttt_pkg::MOVE_W-1:0]         found_best_move_o,
  output logic                                stored_o
);
  import gttt_pkg::*;

  // Moves are kept in the narrower of the move field and MOVE_BITS.
  localparam int MOVE_KEEP = (MOVE_BITS < MOVE_W) ? MOVE_BITS : MOVE_W;
  localparam int SLOT_W    = $bits(slot_t);
  localparam int DATA_W    = SLOT_W + MOVE_KEEP;

  logic [THR_W-1:0]      thr_q;
  logic                  clearing_q;
  logic [INDEX_BITS-1:0] clr_addr_q;
  logic                  busy_q;
  item_t                 item_q;
  logic [MOVE_KEEP-1:0]  item_move_q;
  logic                  out_valid_q;
  result_t               res_q;
  logic [MOVE_KEEP-1:0]  res_move_q;

  logic                  in_fire;
  logic                  done;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  logic [DATA_W-1:0]     mem_wdata;
  logic [DATA_W-1:0]     mem_rdata;
  slot_t                 rd_slot;
  logic [MOVE_KEEP-1:0]  rd_move;
  result_t               calc_res;
  logic [MOVE_KEEP-1:0]  calc_move;
  logic                  calc_we;
  slot_t                 calc_wslot;

  // Handshake: one transaction in flight, none while the table is cleared.
  assign in_ready_o = !clearing_q && !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign done       = busy_q && (!out_valid_q || out_ready_i);

  // Table memory.
  assign mem_we    = clearing_q || (done && calc_we);
  assign mem_waddr = clearing_q ? clr_addr_q : item_q.key[INDEX_BITS-1:0];
  assign mem_wdata = clearing_q ? '0 : {calc_wslot, item_move_q};

  gttt_mem #(
    .ADDR_W (INDEX_BITS),
    .DATA_W (DATA_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_fire),
    .raddr_i (hash_key_i[INDEX_BITS-1:0]),
    .rdata_o (mem_rdata)
  );

  assign rd_slot = mem_rdata[DATA_W-1:MOVE_KEEP];
  assign rd_move = mem_rdata[MOVE_KEEP-1:0];

  // Probe and replacement logic.
  gttt_calc #(
    .MOVE_KEEP (MOVE_KEEP)
  ) u_calc (
    .item_i      (item_q),
    .slot_i      (rd_slot),
    .slot_move_i (rd_move),
    .thr_i       (thr_q),
    .res_o       (calc_res),
    .res_move_o  (calc_move),
    .we_o        (calc_we),
    .wslot_o     (calc_wslot)
  );

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Clearing sweep after reset, one slot per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Transaction in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.kind  <= kind_i;
      item_q.key   <= hash_key_i;
      item_q.depth <= search_depth_i;
      item_q.score <= new_score_i;
      item_q.age   <= new_age_i;
      item_q.stype <= new_score_type_i;
      item_move_q  <= MOVE_KEEP'(new_best_move_i);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q      <= calc_res;
      res_move_q <= calc_move;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign hit_o              = res_q.hit;
  assign found_score_o      = res_q.score;
  assign found_depth_o      = res_q.depth;
  assign found_age_o        = res_q.age;
  assign found_score_type_o = res_q.stype;
  assign found_best_move_o  = MOVE_W'(res_move_q);
  assign stored_o           = res_q.stored;

endmodule

// File: sv/gttt_mem.sv
// ----------------------------------------------------------------------------
// Transposition table storage
// Single-port-write, single-port-read synchronous memory with registered read.
// ----------------------------------------------------------------------------
module gttt_mem #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 121
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/gttt_calc.sv
// ----------------------------------------------------------------------------
// Transposition table probe and replacement logic
// Forms the lookup result or the replacement decision from one slot read.
// ----------------------------------------------------------------------------
module gttt_calc #(
  parameter int MOVE_KEEP = 16
) (
  input  gttt_pkg::item_t                item_i,
  input  gttt_pkg::slot_t                slot_i,
  input  logic [MOVE_KEEP-1:0]           slot_move_i,
  input  logic [gttt_pkg::THR_W-1:0]     thr_i,
  output gttt_pkg::result_t              res_o,
  output logic [MOVE_KEEP-1:0]           res_move_o,
  output logic                           we_o,
  output gttt_pkg::slot_t                wslot_o
);
  import gttt_pkg::*;

  logic               key_match;
  logic signed [AGE_W:0] age_diff;
  logic               age_newer;
  logic               depth_ok;
  logic               is_update;

  assign is_update = (item_i.kind == KIND_UPDATE);
  assign key_match = (slot_i.key == item_i.key);

  // Replacement test: a much newer entry or one searched at least as deep.
  assign age_diff  = $signed({1'b0, item_i.age}) - $signed({1'b0, slot_i.age});
  assign age_newer = (age_diff > $signed((AGE_W+1)'(AGE_MARGIN)));
  assign depth_ok  = (item_i.depth >= slot_i.depth);
  assign we_o      = is_update && (age_newer || depth_ok);

  // Data written on replacement; the score is pulled toward zero once it reaches the threshold.
  always_comb begin
    wslot_o.key   = item_i.key;
    wslot_o.score = mate_adjust(item_i.score, item_i.depth, thr_i, ADJ_TOWARD);
    wslot_o.depth = item_i.depth;
    wslot_o.age   = item_i.age;
    wslot_o.stype = item_i.stype;
  end

  // Result: slot contents on a lookup, only the stored flag on an update.
  always_comb begin
    res_o      = '0;
    res_move_o = '0;
    if (is_update) begin
      res_o.stored = we_o;
    end else begin
      res_o.hit   = key_match;
      res_o.score = key_match
                  ? mate_adjust(slot_i.score, item_i.depth, thr_i, ADJ_AWAY)
                  : slot_i.score;
      res_o.depth = slot_i.depth;
      res_o.age   = slot_i.age;
      res_o.stype = slot_i.stype;
      res_move_o  = slot_move_i;
    end
  end

endmodule
